// ===== sv/byte_memory_access_controller_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BYTE_MEMORY_ACCESS_CONTROLLER_ASSERT_SVH
`define BYTE_MEMORY_ACCESS_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BMAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BMAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bmac_pkg.sv =====
package bmac_pkg;

    // command codes
    localparam logic [4:0] CMD_STOP      = 5'h00;
    localparam logic [4:0] CMD_SET_LO    = 5'h01;
    localparam logic [4:0] CMD_OUT_LO    = 5'h02;
    localparam logic [4:0] CMD_OUT_DATA  = 5'h03;
    localparam logic [4:0] CMD_WRITE     = 5'h04;
    localparam logic [4:0] CMD_WRITE_INC = 5'h05;
    localparam logic [4:0] CMD_WRITE_DEC = 5'h06;
    localparam logic [4:0] CMD_INC       = 5'h07;
    localparam logic [4:0] CMD_DEC       = 5'h08;
    localparam logic [4:0] CMD_SET_HI    = 5'h09;
    localparam logic [4:0] CMD_OUT_HI    = 5'h0A;
    localparam logic [4:0] CMD_OUT_SIZE  = 5'h0B;
    localparam logic [4:0] CMD_SIZE_BUS  = 5'h0C;
    localparam logic [4:0] CMD_SIZE_4    = 5'h0D;
    localparam logic [4:0] CMD_SIZE_3    = 5'h0E;
    localparam logic [4:0] CMD_SIZE_2    = 5'h0F;
    localparam logic [4:0] CMD_SIZE_1    = 5'h10;
    localparam logic [4:0] CMD_OUT_CODE  = 5'h11;

    // cell size codes: bytes per cell = code + 1
    localparam logic [1:0] CODE_BYTES_1 = 2'd0;
    localparam logic [1:0] CODE_BYTES_2 = 2'd1;
    localparam logic [1:0] CODE_BYTES_3 = 2'd2;
    localparam logic [1:0] CODE_BYTES_4 = 2'd3;

    typedef enum logic [2:0] {
        SEL_NONE    = 3'd0,
        SEL_ADDR_LO = 3'd1,
        SEL_DATA    = 3'd2,
        SEL_ADDR_HI = 3'd3,
        SEL_SIZE    = 3'd4,
        SEL_CELL    = 3'd5
    } t_sel;

endpackage

// ===== sv/bmac_ram.sv =====
module bmac_ram #(
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bmac_mod.sv =====
module bmac_mod #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [63:0]                  i_value,
    output logic                         o_done,
    output logic [$clog2(MEM_BYTES)-1:0] o_residue
);

    localparam int IW = $clog2(MEM_BYTES);
    localparam int DigitBits = 16;
    localparam int Digits = 64 / DigitBits;
    localparam int CW = $clog2(Digits);
    localparam int XW = IW + DigitBits;
    localparam int PW = XW + DigitBits + 1;
    localparam logic [XW-1:0] ModX = XW'(MEM_BYTES);
    // floor(2^XW / size): the quotient estimate falls short by at most one
    localparam logic [DigitBits:0] Recip = (DigitBits+1)'((64'd1 << XW) / 64'(MEM_BYTES));
    localparam logic [CW-1:0] LastDigit = CW'(Digits - 1);

    logic                 r_busy;
    logic                 r_phase;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [63:0]          r_shift;
    logic [IW-1:0]        r_rem;
    logic [XW-1:0]        r_x;
    logic [DigitBits:0]   r_q;
    logic [XW-1:0]        n_x;
    logic [PW-1:0]        n_prod;
    logic [XW-1:0]        n_diff;
    logic [IW-1:0]        n_rem;

    // Horner form, one 16-bit digit per estimate and correct pass: rem = (rem * 2^16 + digit) mod size
    assign n_x    = {r_rem, r_shift[63 -: DigitBits]};
    assign n_prod = PW'(n_x) * PW'(Recip);
    assign n_diff = r_x - XW'(r_q) * ModX;
    assign n_rem  = (n_diff >= ModX) ? IW'(n_diff - ModX) : n_diff[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else if (r_busy && !r_phase) begin
            // estimate the quotient for the next digit
            r_x     <= n_x;
            r_q     <= n_prod[XW +: DigitBits+1];
            r_shift <= {r_shift[63-DigitBits:0], {DigitBits{1'b0}}};
            r_phase <= 1'b1;
            r_done  <= 1'b0;
        end else if (r_busy) begin
            // subtract and correct once
            r_rem   <= n_rem;
            r_phase <= 1'b0;
            r_cnt   <= r_cnt + 1'b1;
            r_busy  <= (r_cnt != LastDigit);
            r_done  <= (r_cnt == LastDigit);
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done    = r_done;
    assign o_residue = r_rem;

endmodule

// ===== sv/byte_memory_access_controller.sv =====
// Each command passes S_IDLE, S_EXEC and S_FINISH to S_DONE, where the result is registered;
// a cell write steps S_WRITE once per byte of the cell, while data output is selected every
// command reads the cell byte by byte in S_READ, and an address-half load waits in S_REDUCE
// while the 64-bit address is reduced modulo MEM_BYTES sixteen bits at a time. One command is
// taken at a time; a result still waiting on i_ready holds the next one in S_DONE. Reset:
// synchronous; afterwards the memory is cleared one byte a cycle, all MEM_BYTES bytes, with o_ready low throughout.
module byte_memory_access_controller #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_kind,
    input  logic [31:0] i_bus_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_word,
    output logic        o_read_valid
);

    import bmac_pkg::*;

    localparam int IW = $clog2(MEM_BYTES);
    localparam logic [IW-1:0] PtrLast = IW'(MEM_BYTES - 1);
    localparam logic [IW+2:0] Mod1 = (IW+3)'(MEM_BYTES);
    localparam logic [IW+2:0] Mod2 = (IW+3)'(2 * MEM_BYTES);
    localparam logic [63:0] AllOnesRes = 64'hFFFF_FFFF_FFFF_FFFF % 64'(MEM_BYTES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_REDUCE,
        S_WRITE,
        S_FINISH,
        S_READ,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [4:0]    r_kind;
    logic [31:0]   r_bus;
    logic [63:0]   r_addr;
    logic [IW-1:0] r_amod;
    logic [1:0]    r_code;
    t_sel          r_sel;
    logic [IW-1:0] r_ptr;
    logic [2:0]    r_cnt;
    logic [31:0]   r_word;
    logic          r_rvalid;
    logic          r_mod_start;
    logic          r_out_valid;
    logic [31:0]   r_out_word;
    logic          r_out_rvalid;

    logic [IW+2:0] n_prod;
    logic [IW+2:0] n_red;
    logic [IW-1:0] n_base;
    logic [IW-1:0] n_ptr_nx;
    logic [IW-1:0] n_amod_inc;
    logic [IW-1:0] n_amod_dec;
    logic [1:0]    n_rd_idx;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic          mod_done;
    logic [IW-1:0] mod_residue;

    // first byte of the cell: (address mod size) * bytes per cell, mod size
    always_comb begin
        n_prod = (IW+3)'(r_amod) * (IW+3)'({1'b0, r_code} + 3'd1);
        n_red  = (n_prod >= Mod2) ? n_prod - Mod2 : n_prod;
        n_base = (n_red >= Mod1) ? IW'(n_red - Mod1) : n_red[IW-1:0];
    end

    assign n_ptr_nx = (r_ptr == PtrLast) ? '0 : r_ptr + 1'b1;

    // keep the residue in step with the 64-bit address, wrap at both ends
    always_comb begin
        if (r_addr == '1) begin
            n_amod_inc = '0;
        end else if (r_amod == PtrLast) begin
            n_amod_inc = '0;
        end else begin
            n_amod_inc = r_amod + 1'b1;
        end
        if (r_addr == '0) begin
            n_amod_dec = AllOnesRes[IW-1:0];
        end else if (r_amod == '0) begin
            n_amod_dec = PtrLast;
        end else begin
            n_amod_dec = r_amod - 1'b1;
        end
    end

    assign n_rd_idx = 2'(r_cnt - 3'd1);

    always_comb begin
        mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        mem_wdata = '0;
        if (r_state == S_WRITE) begin
            unique case (r_cnt[1:0])
                2'd0: mem_wdata = r_bus[7:0];
                2'd1: mem_wdata = r_bus[15:8];
                2'd2: mem_wdata = r_bus[23:16];
                2'd3: mem_wdata = r_bus[31:24];
            endcase
        end
    end

    bmac_ram #(
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (r_ptr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    bmac_mod #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mod_start),
        .i_value   (r_addr),
        .o_done    (mod_done),
        .o_residue (mod_residue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_amod      <= '0;
            r_code      <= CODE_BYTES_4;
            r_sel       <= SEL_NONE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mod_start <= (r_state == S_EXEC)
                           && ((r_kind == CMD_SET_LO) || (r_kind == CMD_SET_HI));
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_ptr <= n_ptr_nx;
                    if (r_ptr == PtrLast) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_valid) begin
                        r_kind  <= i_kind;
                        r_bus   <= i_bus_word;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if ((r_kind == CMD_SET_LO) || (r_kind == CMD_SET_HI)) begin
                        r_state <= S_REDUCE;
                    end else if ((r_kind == CMD_WRITE) || (r_kind == CMD_WRITE_INC)
                                 || (r_kind == CMD_WRITE_DEC)) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_FINISH;
                    end
                    case (r_kind)
                        CMD_STOP:     r_sel <= SEL_NONE;
                        CMD_SET_LO:   r_addr[31:0] <= r_bus;
                        CMD_OUT_LO:   r_sel <= SEL_ADDR_LO;
                        CMD_OUT_DATA: r_sel <= SEL_DATA;
                        CMD_WRITE, CMD_WRITE_INC, CMD_WRITE_DEC: begin
                            r_ptr <= n_base;
                            r_cnt <= '0;
                        end
                        CMD_INC: begin
                            r_addr <= r_addr + 64'd1;
                            r_amod <= n_amod_inc;
                        end
                        CMD_DEC: begin
                            r_addr <= r_addr - 64'd1;
                            r_amod <= n_amod_dec;
                        end
                        CMD_SET_HI:   r_addr[63:32] <= r_bus;
                        CMD_OUT_HI:   r_sel  <= SEL_ADDR_HI;
                        CMD_OUT_SIZE: r_sel  <= SEL_SIZE;
                        CMD_SIZE_BUS: r_code <= r_bus[1:0];
                        CMD_SIZE_4:   r_code <= CODE_BYTES_4;
                        CMD_SIZE_3:   r_code <= CODE_BYTES_3;
                        CMD_SIZE_2:   r_code <= CODE_BYTES_2;
                        CMD_SIZE_1:   r_code <= CODE_BYTES_1;
                        CMD_OUT_CODE: r_sel  <= SEL_CELL;
                        default:      r_sel  <= r_sel;
                    endcase
                end

                S_REDUCE: begin
                    if (mod_done) begin
                        r_amod  <= mod_residue;
                        r_state <= S_FINISH;
                    end
                end

                S_WRITE: begin
                    r_ptr <= n_ptr_nx;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt[1:0] == r_code) begin
                        // post-step after the last byte
                        if (r_kind == CMD_WRITE_INC) begin
                            r_addr <= r_addr + 64'd1;
                            r_amod <= n_amod_inc;
                        end else if (r_kind == CMD_WRITE_DEC) begin
                            r_addr <= r_addr - 64'd1;
                            r_amod <= n_amod_dec;
                        end
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    r_rvalid <= (r_sel != SEL_NONE);
                    r_state  <= (r_sel == SEL_DATA) ? S_READ : S_DONE;
                    case (r_sel)
                        SEL_ADDR_LO: r_word <= r_addr[31:0];
                        SEL_ADDR_HI: r_word <= r_addr[63:32];
                        SEL_SIZE:    r_word <= 32'(MEM_BYTES);
                        SEL_CELL:    r_word <= {30'd0, r_code};
                        SEL_DATA: begin
                            r_word <= '0;
                            r_ptr  <= n_base;
                            r_cnt  <= '0;
                        end
                        default:     r_word <= '0;
                    endcase
                end

                S_READ: begin
                    // read issued at r_ptr, byte lands in the next cycle
                    r_ptr <= n_ptr_nx;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_word[8*n_rd_idx +: 8] <= mem_rdata;
                    end
                    if (r_cnt == {1'b0, r_code} + 3'd1) begin
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_word   <= r_word;
                        r_out_rvalid <= r_rvalid;
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_read_word  = r_out_word;
    assign o_read_valid = r_out_rvalid;

endmodule

// ===== sv/bmac_checker.sv =====
`include "byte_memory_access_controller_assert.svh"

module bmac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [4:0]  i_kind,
    input logic [31:0] i_bus_word,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_read_word,
    input logic        o_read_valid
);

    // no beat out and no beat taken straight after reset: the memory sweep runs first
    `BMAC_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n), !o_valid && !o_ready, "beat right after reset")

    // a result with no selection carries a zero word
    `BMAC_ASSERT_IMP(a_none_is_zero, i_clk, i_rst_n, o_valid && !o_read_valid, o_read_word == 32'd0, "undriven result not zero")

    // one command in flight: ready drops after each accepted beat
    `BMAC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second beat taken while busy")

    `BMAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_read_word) && $stable(o_read_valid), "stalled result changed")

endmodule

bind byte_memory_access_controller bmac_checker u_bmac_checker (.*);

// ===== verif/byte_memory_access_controller_tb.sv =====
module byte_memory_access_controller_tb;
    import bmac_pkg::*;

    localparam int MEM_BYTES = 65536;
    localparam int N_RANDOM = 1900;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [31:0] word;
        logic        valid;
    } t_result;

    typedef struct {
        logic [4:0]  kind;
        logic [31:0] bus;
        bit          known;
        logic [31:0] word;
        logic        valid;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [4:0]  i_kind = 5'd0;
    logic [31:0] i_bus_word = 32'd0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_read_word;
    logic        o_read_valid;

    // predictor state
    logic [63:0] cell_addr;
    logic [1:0]  size_code;
    t_sel        out_sel;
    logic [7:0]  bytes_mirror [0:MEM_BYTES-1];

    t_result     due_results [$];
    int          mismatches = 0;
    bit          steady_flow = 1'b0;
    bit          rx_hold_req = 1'b0;
    t_row        directed_rows [0:25];

    byte_memory_access_controller #(
        .MEM_BYTES(MEM_BYTES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_kind(i_kind),
        .i_bus_word(i_bus_word),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_read_word(o_read_word),
        .o_read_valid(o_read_valid)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20000000;
        $display("byte_memory_access_controller_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] cell_base();
        return ((cell_addr % 64'(MEM_BYTES)) * (64'(size_code) + 64'd1)) % 64'(MEM_BYTES);
    endfunction

    function automatic void store_cell(logic [31:0] data);
        logic [63:0] base;
        base = cell_base();
        for (int i = 0; i <= int'(size_code); i++)
            bytes_mirror[(base + 64'(i)) % 64'(MEM_BYTES)] = data[8*i +: 8];
    endfunction

    function automatic logic [31:0] load_cell();
        logic [63:0] base;
        logic [31:0] data;
        base = cell_base();
        data = '0;
        for (int i = 0; i <= int'(size_code); i++)
            data[8*i +: 8] = bytes_mirror[(base + 64'(i)) % 64'(MEM_BYTES)];
        return data;
    endfunction

    // perform one bus command on the mirror and return what the bus shows afterwards
    function automatic t_result execute_command(logic [4:0] kind, logic [31:0] bus);
        t_result r;
        case (kind)
            CMD_STOP:      out_sel = SEL_NONE;
            CMD_SET_LO:    cell_addr[31:0] = bus;
            CMD_OUT_LO:    out_sel = SEL_ADDR_LO;
            CMD_OUT_DATA:  out_sel = SEL_DATA;
            CMD_WRITE:     store_cell(bus);
            CMD_WRITE_INC: begin
                store_cell(bus);
                cell_addr = cell_addr + 64'd1;
            end
            CMD_WRITE_DEC: begin
                store_cell(bus);
                cell_addr = cell_addr - 64'd1;
            end
            CMD_INC:       cell_addr = cell_addr + 64'd1;
            CMD_DEC:       cell_addr = cell_addr - 64'd1;
            CMD_SET_HI:    cell_addr[63:32] = bus;
            CMD_OUT_HI:    out_sel = SEL_ADDR_HI;
            CMD_OUT_SIZE:  out_sel = SEL_SIZE;
            CMD_SIZE_BUS:  size_code = bus[1:0];
            CMD_SIZE_4:    size_code = CODE_BYTES_4;
            CMD_SIZE_3:    size_code = CODE_BYTES_3;
            CMD_SIZE_2:    size_code = CODE_BYTES_2;
            CMD_SIZE_1:    size_code = CODE_BYTES_1;
            CMD_OUT_CODE:  out_sel = SEL_CELL;
            default: ;
        endcase
        r.valid = 1'b1;
        case (out_sel)
            SEL_ADDR_LO: r.word = cell_addr[31:0];
            SEL_ADDR_HI: r.word = cell_addr[63:32];
            SEL_SIZE:    r.word = 32'(MEM_BYTES);
            SEL_CELL:    r.word = {30'd0, size_code};
            SEL_DATA:    r.word = load_cell();
            default: begin
                r.word = 32'd0;
                r.valid = 1'b0;
            end
        endcase
        return r;
    endfunction

    task automatic send_beat(input logic [4:0] kind, input logic [31:0] bus, input bit known,
                             input logic [31:0] word, input logic valid);
        t_result r;
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < 18) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_bus_word <= bus;
        do @(posedge i_clk); while (!o_ready);
        r = execute_command(kind, bus);
        if (known) begin
            r.word = word;
            r.valid = valid;
        end
        due_results.push_back(r);
    endtask

    // receiver: random stalls, a quiet stretch and one long hold-off
    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else begin
                i_ready <= steady_flow || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result beat", o_read_word, 32'd0);
            end else begin
                e = due_results.pop_front();
                if (o_read_word !== e.word)
                    report_mismatch("read_word", o_read_word, e.word);
                if (o_read_valid !== e.valid)
                    report_mismatch("read_valid", 32'(o_read_valid), 32'(e.valid));
            end
        end
    end

    initial begin
        int used;
        int pick;
        int waited;
        logic [4:0] k;
        logic [31:0] w;

        cell_addr = '0;
        size_code = CODE_BYTES_4;
        out_sel = SEL_NONE;
        for (int i = 0; i < MEM_BYTES; i++)
            bytes_mirror[i] = 8'd0;

        directed_rows = '{
            '{CMD_OUT_SIZE,  32'h0,        1'b1, 32'(MEM_BYTES), 1'b1},
            '{CMD_OUT_CODE,  32'h0,        1'b1, 32'd3,          1'b1},
            '{CMD_OUT_DATA,  32'h0,        1'b1, 32'h0,          1'b1},
            '{CMD_OUT_LO,    32'h0,        1'b1, 32'h0,          1'b1},
            '{CMD_SET_LO,    32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,   1'b1},
            '{CMD_SET_HI,    32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF,   1'b1},
            '{CMD_OUT_HI,    32'h0,        1'b1, 32'hFFFFFFFF,   1'b1},
            // all-ones address steps round to zero and back
            '{CMD_INC,       32'h0,        1'b1, 32'h0,          1'b1},
            '{CMD_DEC,       32'h0,        1'b1, 32'hFFFFFFFF,   1'b1},
            '{CMD_SET_HI,    32'h0,        1'b1, 32'h0,          1'b1},
            '{CMD_SET_LO,    32'h0000AAAA, 1'b1, 32'h0,          1'b1},
            // only the two low bus bits pick the size
            '{CMD_SIZE_BUS,  32'hFFFFFFFE, 1'b1, 32'h0,          1'b1},
            '{CMD_OUT_CODE,  32'h0,        1'b1, 32'd2,          1'b1},
            // three-byte cell at the top of memory wraps its last byte to zero
            '{CMD_WRITE,     32'hFFCCBBAA, 1'b1, 32'd2,          1'b1},
            '{CMD_OUT_DATA,  32'h0,        1'b1, 32'h00CCBBAA,   1'b1},
            '{CMD_SIZE_4,    32'h0,        1'b0, 32'h0,          1'b0},
            '{CMD_SET_LO,    32'h0,        1'b0, 32'h0,          1'b0},
            '{CMD_WRITE_INC, 32'h11223344, 1'b0, 32'h0,          1'b0},
            '{CMD_WRITE_DEC, 32'h55667788, 1'b0, 32'h0,          1'b0},
            '{CMD_SIZE_1,    32'h0,        1'b0, 32'h0,          1'b0},
            '{CMD_WRITE_DEC, 32'hFFFFFFFF, 1'b0, 32'h0,          1'b0},
            '{CMD_SIZE_3,    32'h0,        1'b0, 32'h0,          1'b0},
            '{CMD_SIZE_2,    32'h0,        1'b0, 32'h0,          1'b0},
            '{5'h1F,         32'hFFFFFFFF, 1'b0, 32'h0,          1'b0},
            '{CMD_OUT_LO,    32'h0,        1'b1, 32'hFFFFFFFF,   1'b1},
            '{CMD_STOP,      32'h0,        1'b1, 32'h0,          1'b0}
        };

        while (i_rst_n !== 1'b1) @(posedge i_clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].kind, directed_rows[i].bus, directed_rows[i].known,
                      directed_rows[i].word, directed_rows[i].valid);

        used = 0;
        while (used < N_RANDOM) begin
            if (used == 300)
                rx_hold_req = 1'b1;
            steady_flow = (used >= 600 && used < 900);
            if (used == 1000) begin
                // drain everything before carrying on
                i_valid <= 1'b0;
                do @(posedge i_clk); while (due_results.size() != 0);
            end

            pick = $urandom_range(0, 99);
            w = $urandom;
            if (pick < 5) begin
                k = 5'($urandom_range(18, 31));
            end else if (pick < 17) begin
                k = CMD_SET_LO;
                if ($urandom_range(0, 3) != 0)
                    w = $urandom_range(0, 40);
            end else if (pick < 22) begin
                k = CMD_SET_HI;
                if ($urandom_range(0, 1) != 0)
                    w = 32'd0;
            end else if (pick < 47) begin
                case ($urandom_range(0, 2))
                    0:       k = CMD_WRITE;
                    1:       k = CMD_WRITE_INC;
                    default: k = CMD_WRITE_DEC;
                endcase
            end else if (pick < 57) begin
                k = ($urandom_range(0, 1) != 0) ? CMD_INC : CMD_DEC;
            end else if (pick < 65) begin
                case ($urandom_range(0, 4))
                    0:       k = CMD_SIZE_BUS;
                    1:       k = CMD_SIZE_4;
                    2:       k = CMD_SIZE_3;
                    3:       k = CMD_SIZE_2;
                    default: k = CMD_SIZE_1;
                endcase
            end else if (pick < 80) begin
                k = CMD_OUT_DATA;
            end else begin
                case ($urandom_range(0, 4))
                    0:       k = CMD_STOP;
                    1:       k = CMD_OUT_LO;
                    2:       k = CMD_OUT_HI;
                    3:       k = CMD_OUT_SIZE;
                    default: k = CMD_OUT_CODE;
                endcase
            end

            send_beat(k, w, 1'b0, 32'h0, 1'b0);
            if (k <= CMD_OUT_CODE)
                used++;
        end
        steady_flow = 1'b0;
        i_valid <= 1'b0;

        waited = 0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", 32'(due_results.size()), 32'd0);

        if (mismatches == 0) begin
            $display("byte_memory_access_controller_tb: PASS");
        end else begin
            $display("byte_memory_access_controller_tb: FAIL");
        end
        $finish;
    end

endmodule
